### hdl/flct_pkg.sv
// ----------------------------------------------------------------------------
// flct_pkg
// Shared types and constants of the filtered list cursor table: payload
// words, operation codes, register indexes and the controller/datapath link.
// ----------------------------------------------------------------------------
`default_nettype none

package flct_pkg;

  // table geometry
  localparam int DEPTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // field widths of the payload words
  localparam int KIND_W = 3;
  localparam int INDEX_W = 8;
  localparam int TYPE_W = 8;
  localparam int POS_W = 5;
  localparam int COUNT_W = 6;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_UPDATE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SELECT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NEXT = 3'd4;
  localparam logic [KIND_W-1:0] KIND_PREV = 3'd5;
  localparam logic [KIND_W-1:0] KIND_QUERY = 3'd6;

  // configuration register indexes
  localparam int REG_IDX_W = 1;
  localparam int REG_DATA_W = 8;
  localparam logic [REG_IDX_W-1:0] REG_TYPE_FILTER = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_FAV_ONLY = 1'd1;

  // type filter value that lets every type pass
  localparam logic [TYPE_W-1:0] TYPE_ANY = 8'hFF;

  // input word
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] index;
    logic [TYPE_W-1:0]  entry_type;
    logic               entry_favorite;
  } item_t;

  // result word
  typedef struct packed {
    logic               ok;
    logic [POS_W-1:0]   written_index;
    logic [COUNT_W-1:0] entry_count;
    logic [COUNT_W-1:0] match_count;
    logic               cursor_valid;
    logic [POS_W-1:0]   cursor_position;
    logic [TYPE_W-1:0]  cursor_type;
    logic               cursor_favorite;
  } result_t;

  // one stored entry
  typedef struct packed {
    logic [TYPE_W-1:0] etype;
    logic              fav;
  } entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
    logic shift_rd;
    logic shift_wr;
    logic del_end;
    logic scan_start;
    logic scan;
    logic find;
    logic step;
    logic move;
    logic cur_rd;
    logic capture;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              idx_ok;
    logic              shift_more;
    logic              scan_done;
    logic              fc_zero;
  } dp_status_t;

endpackage

`default_nettype wire

### hdl/filtered_list_cursor_table.sv
// ----------------------------------------------------------------------------
// filtered_list_cursor_table
// Ordered, compacted table of up to 32 entries with a count, a selection
// cursor and a type/favourite filter; one result word per command word.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; busy then stays
// high until the result word appears on result for exactly one cycle with
// done high, and it must be taken in that cycle since the block cannot hold
// it. Every command runs a scan of the held entries through the single read
// port of the entry memory, one entry a cycle; a valid delete first shifts
// each later entry down one place (read then write through the same port),
// and next/prev add a second scan to find the new cursor position when any
// entry passes the filter. The longest command is a delete at position 0 of
// a full table. Configuration writes on wr_en/wr_index/wr_data take effect
// at once and belong between commands. The entry memory needs no clearing
// pass.
// ----------------------------------------------------------------------------
`default_nettype none

module filtered_list_cursor_table import flct_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire item_t                 item,
  output logic                       done,
  output result_t                    result,
  input  wire logic                  wr_en,
  input  wire logic [REG_IDX_W-1:0]  wr_index,
  input  wire logic [REG_DATA_W-1:0] wr_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  flct_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd)
  );

  // table, cursor and scan datapath
  flct_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cmd      (cmd),
    .status   (status),
    .result   (result)
  );

endmodule

`default_nettype wire

### hdl/flct_dp.sv
// ----------------------------------------------------------------------------
// flct_dp
// Datapath: entry memory, count and cursor registers, filter registers,
// pipelined scan over the held entries, shift for delete, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module flct_dp import flct_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire item_t                 item,
  input  wire logic                  wr_en,
  input  wire logic [REG_IDX_W-1:0]  wr_index,
  input  wire logic [REG_DATA_W-1:0] wr_data,
  input  wire dp_cmd_t               cmd,
  output dp_status_t                 status,
  output result_t                    result
);

  // entry memory, no reset: only positions below the count are used
  entry_t mem [DEPTH];
  entry_t rdata;

  // control state
  logic [CNT_W-1:0]  held;
  logic [IDX_W-1:0]  cur_idx;
  logic              cur_set;
  logic [TYPE_W-1:0] tfilt;
  logic              fonly;

  // per-word working registers
  item_t             lat;
  logic              ok;
  logic [IDX_W-1:0]  written;
  logic [IDX_W-1:0]  sp;
  logic [CNT_W-1:0]  scan_addr;
  logic              pend;
  logic [IDX_W-1:0]  pend_pos;
  logic [CNT_W-1:0]  fc_acc;
  logic [CNT_W-1:0]  rank_acc;
  logic              cur_pass;
  logic [CNT_W-1:0]  nr;
  logic [IDX_W-1:0]  found_pos;
  result_t           res;

  // combinational helpers
  logic              full;
  logic              idx_ok;
  logic              shift_more;
  logic              pass;
  logic [CNT_W-1:0]  rank;
  logic [CNT_W-1:0]  held_dec;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  entry_t            wdata;
  logic [IDX_W-1:0]  raddr;

  assign full = (held == CNT_W'(DEPTH));
  assign idx_ok = (16'(lat.index) < 16'(held));
  assign shift_more = ((CNT_W'(sp) + CNT_W'(1)) < held);
  assign held_dec = held - CNT_W'(1);

  // filter test on the entry read back last cycle
  assign pass = ((tfilt == TYPE_ANY) || (rdata.etype == tfilt)) && (!fonly || rdata.fav);

  // filtered rank of the cursor, zero when the cursor is unset or outside the filtered set
  assign rank = (cur_set && cur_pass) ? rank_acc : '0;

  // memory write port
  always_comb begin
    we = 1'b0;
    waddr = lat.index[IDX_W-1:0];
    wdata = '{etype: lat.entry_type, fav: lat.entry_favorite};
    if (cmd.shift_wr) begin
      we = 1'b1;
      waddr = sp;
      wdata = rdata;
    end else if (cmd.exec && lat.kind == KIND_ADD) begin
      we = !full;
      waddr = held[IDX_W-1:0];
    end else if (cmd.exec && lat.kind == KIND_UPDATE) begin
      we = idx_ok;
    end
  end

  // memory read address
  always_comb begin
    if (cmd.shift_rd) begin
      raddr = sp + IDX_W'(1);
    end else if (cmd.cur_rd) begin
      raddr = cur_idx;
    end else begin
      raddr = scan_addr[IDX_W-1:0];
    end
  end

  // memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // count, cursor and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
      cur_idx <= '0;
      cur_set <= 1'b0;
      tfilt <= TYPE_ANY;
      fonly <= 1'b0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_TYPE_FILTER: tfilt <= wr_data;
          REG_FAV_ONLY:    fonly <= wr_data[0];
          default: ;
        endcase
      end
      if (cmd.exec) begin
        case (lat.kind)
          KIND_ADD: begin
            if (!full) begin
              held <= held + CNT_W'(1);
              if (!cur_set) begin
                cur_set <= 1'b1;
                cur_idx <= '0;
              end
            end
          end
          KIND_SELECT: begin
            if (idx_ok) begin
              cur_idx <= lat.index[IDX_W-1:0];
              cur_set <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      // end of delete: drop the count and clamp the cursor
      if (cmd.del_end) begin
        held <= held_dec;
        if (held_dec == '0) begin
          cur_set <= 1'b0;
          cur_idx <= '0;
        end else if (cur_set && CNT_W'(cur_idx) >= held_dec) begin
          cur_idx <= IDX_W'(held_dec - CNT_W'(1));
        end
      end
      if (cmd.move) begin
        cur_idx <= found_pos;
        cur_set <= 1'b1;
      end
    end
  end

  // working registers of one word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lat <= item;
      ok <= 1'b0;
      written <= '0;
    end
    if (cmd.exec) begin
      sp <= lat.index[IDX_W-1:0];
      case (lat.kind)
        KIND_ADD: begin
          ok <= !full;
          if (!full) begin
            written <= held[IDX_W-1:0];
          end
        end
        KIND_UPDATE, KIND_DELETE, KIND_SELECT: ok <= idx_ok;
        KIND_QUERY: ok <= 1'b1;
        default: ok <= 1'b0;
      endcase
    end
    if (cmd.shift_wr) begin
      sp <= sp + IDX_W'(1);
    end
    if (cmd.move) begin
      ok <= 1'b1;
    end

    // pipelined scan: issue one read a cycle, judge it the cycle after
    if (cmd.scan_start) begin
      scan_addr <= '0;
      pend <= 1'b0;
      fc_acc <= '0;
      rank_acc <= '0;
      cur_pass <= 1'b0;
    end else if (cmd.scan) begin
      if (scan_addr < held) begin
        pend <= 1'b1;
        pend_pos <= scan_addr[IDX_W-1:0];
        scan_addr <= scan_addr + CNT_W'(1);
      end else begin
        pend <= 1'b0;
      end
      if (pend) begin
        if (pass) begin
          fc_acc <= fc_acc + CNT_W'(1);
          if (pend_pos < cur_idx) begin
            rank_acc <= rank_acc + CNT_W'(1);
          end
          if (cmd.find && fc_acc == nr) begin
            found_pos <= pend_pos;
          end
        end
        if (pend_pos == cur_idx) begin
          cur_pass <= pass;
        end
      end
    end

    // target rank for next or prev
    if (cmd.step) begin
      if (lat.kind == KIND_NEXT) begin
        nr <= (rank + CNT_W'(1) == fc_acc) ? '0 : rank + CNT_W'(1);
      end else begin
        nr <= (rank == '0) ? fc_acc - CNT_W'(1) : rank - CNT_W'(1);
      end
    end

    // result word
    if (cmd.capture) begin
      res.ok <= ok;
      res.written_index <= POS_W'(written);
      res.entry_count <= COUNT_W'(held);
      res.match_count <= COUNT_W'(fc_acc);
      res.cursor_valid <= cur_set;
      res.cursor_position <= cur_set ? POS_W'(cur_idx) : '0;
      res.cursor_type <= cur_set ? rdata.etype : '0;
      res.cursor_favorite <= cur_set ? rdata.fav : 1'b0;
    end
  end

  // status to the controller
  assign status.kind = lat.kind;
  assign status.idx_ok = idx_ok;
  assign status.shift_more = shift_more;
  assign status.scan_done = (scan_addr >= held) && !pend;
  assign status.fc_zero = (fc_acc == '0);

  assign result = res;

  // a set cursor always points at a held entry
  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    cur_set |-> (CNT_W'(cur_idx) < held))
    else $error("cursor beyond held entries");

  // an unset cursor rests at position zero
  a_cursor_unset_zero: assert property (@(posedge clk) disable iff (rst)
    !cur_set |-> (cur_idx == '0))
    else $error("unset cursor not at zero");

  // the count never passes the table depth
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

endmodule

`default_nettype wire

### hdl/flct_ctrl.sv
// ----------------------------------------------------------------------------
// flct_ctrl
// Controller: sequences one word through execute, delete shift, filter scans,
// cursor step, cursor read and result capture.
// ----------------------------------------------------------------------------
`default_nettype none

module flct_ctrl import flct_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire dp_status_t status,
  output logic            busy,
  output logic            done,
  output dp_cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SCAN_RANK,
    S_STEP,
    S_SCAN_FIND,
    S_MOVE,
    S_SCAN_COUNT,
    S_CUR_RD,
    S_CAPTURE
  } state_t;

  state_t state;
  state_t state_next;

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (status.kind == KIND_DELETE && status.idx_ok) begin
          state_next = S_SHIFT_RD;
        end else if (status.kind == KIND_NEXT || status.kind == KIND_PREV) begin
          cmd.scan_start = 1'b1;
          state_next = S_SCAN_RANK;
        end else begin
          cmd.scan_start = 1'b1;
          state_next = S_SCAN_COUNT;
        end
      end
      S_SHIFT_RD: begin
        if (status.shift_more) begin
          cmd.shift_rd = 1'b1;
          state_next = S_SHIFT_WR;
        end else begin
          cmd.del_end = 1'b1;
          cmd.scan_start = 1'b1;
          state_next = S_SCAN_COUNT;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_next = S_SHIFT_RD;
      end
      S_SCAN_RANK: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        if (status.fc_zero) begin
          state_next = S_CUR_RD;
        end else begin
          cmd.step = 1'b1;
          cmd.scan_start = 1'b1;
          state_next = S_SCAN_FIND;
        end
      end
      S_SCAN_FIND: begin
        cmd.scan = 1'b1;
        cmd.find = 1'b1;
        if (status.scan_done) begin
          state_next = S_MOVE;
        end
      end
      S_MOVE: begin
        cmd.move = 1'b1;
        state_next = S_CUR_RD;
      end
      S_SCAN_COUNT: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_next = S_CUR_RD;
        end
      end
      S_CUR_RD: begin
        cmd.cur_rd = 1'b1;
        state_next = S_CAPTURE;
      end
      S_CAPTURE: begin
        cmd.capture = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      busy <= (state_next != S_IDLE);
      done <= (state == S_CAPTURE);
    end
  end

  // a taken word makes the block busy on the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("word taken but block not busy");

  // the result strobe comes only once the block is free again
  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(state == S_CAPTURE)))
    else $error("result strobe outside capture");

endmodule

`default_nettype wire
